/* design/tts_pkg.sv */
// Shared types, channel codes and update arithmetic for the task timing statistics block.
package tts_pkg;

  localparam int NUM_CH = 3;

  typedef enum logic [1:0] {
    CH_PROC = 2'd0,
    CH_KERN = 2'd1,
    CH_EXC  = 2'd2
  } channel_t;

  typedef struct packed {
    logic [15:0] minimum;
    logic [15:0] maximum;
    logic [15:0] average;
    logic [63:0] total;
  } stat_t;

  typedef stat_t [NUM_CH-1:0] row_t;

  typedef logic [NUM_CH-1:0][15:0] samples_t;

  // Exponential average: (avg * (2^sh - 1) + smp) >> sh, done with a shift and two adds.
  function automatic logic [15:0] avg_step(input logic [15:0] avg, input logic [15:0] smp,
                                           input logic [3:0] sh);
    logic [31:0] acc;
    acc = (32'(avg) << sh) - 32'(avg) + 32'(smp);
    return 16'(acc >> sh);
  endfunction

  // A zero minimum or zero average counts as unset.
  function automatic stat_t stat_update(input stat_t old, input logic [15:0] smp,
                                        input logic [3:0] sh);
    stat_t       upd;
    logic [15:0] seed;
    seed           = (old.average == 16'd0) ? smp : old.average;
    upd.minimum    = (old.minimum > smp || old.minimum == 16'd0) ? smp : old.minimum;
    upd.maximum    = (old.maximum < smp) ? smp : old.maximum;
    upd.average    = avg_step(seed, smp, sh);
    upd.total      = old.total + 64'(smp);
    return upd;
  endfunction

endpackage

/* design/task_timing_statistics.sv */
// Top level of the task timing statistics block: per-process min, max, average and sum.
//
//  Channel  Ports                                   Beat
//  -------  --------------------------------------  ---------------------------------
//  input    in_valid / in_ready, in_* fields         one context switch
//  result   out_valid / out_ready, out_* fields      one channel; three beats a switch
//  config   cfg_we, cfg_wdata                        avg_shift, written at once
//
// A switch is registered with its table rows read on the accept edge, is folded into the
// tables as it enters the result register, then leaves as three beats in channel order.
// The result register drains one beat per cycle while out_ready stays high, and the next
// switch is accepted while the current beats drain.
// Reset clears the tables through per-process valid bits.
// A stalled result holds its beat and, once the input register is full, in_ready.
module task_timing_statistics #(
  parameter int NUM_PROCESSES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_left_process,
  input  logic [3:0]  in_running_process,
  input  logic [15:0] in_stamp_start,
  input  logic [15:0] in_stamp_stop,
  input  logic [15:0] in_stamp_last_start,
  input  logic [15:0] in_exception_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_channel,
  output logic [15:0] out_sample,
  output logic [15:0] out_minimum,
  output logic [15:0] out_maximum,
  output logic [15:0] out_average,
  output logic [63:0] out_total,
  output logic [31:0] out_run_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam logic [8:0] NP = 9'(NUM_PROCESSES);

  // Process ids at or beyond the table size fold back by repeated subtraction.
  function automatic logic [3:0] proc_mod(input logic [3:0] v);
    logic [8:0] r;
    r = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= NP) r = r - NP;
    end
    return r[3:0];
  endfunction

  logic [3:0] shift_r;

  // Table storage and per-process valid bits.
  tts_pkg::row_t       stat_mem_r [NUM_PROCESSES];
  logic [31:0]         cnt_mem_r  [NUM_PROCESSES];
  logic [NUM_PROCESSES-1:0] row_set_r;
  logic [NUM_PROCESSES-1:0] cnt_set_r;

  // Input register stage.
  logic                a_vld_r;
  logic [PW-1:0]       a_left_r;
  logic [PW-1:0]       a_run_r;
  tts_pkg::samples_t   a_smp_r;
  tts_pkg::row_t       rd_row_r;
  logic [31:0]         rd_cnt_r;
  logic                rd_row_set_r;
  logic                rd_cnt_set_r;
  logic                fwd_row_r;
  logic                fwd_cnt_r;

  // Result register stage.
  logic                res_vld_r;
  logic                res_vld_nxt;
  tts_pkg::channel_t   beat_r;
  tts_pkg::channel_t   beat_nxt;
  tts_pkg::row_t       res_row_r;
  tts_pkg::samples_t   res_smp_r;
  logic [31:0]         res_cnt_r;

  logic                in_acc;
  logic                out_acc;
  logic                res_free;
  logic                move;
  logic [PW-1:0]       in_left_idx;
  logic [PW-1:0]       in_run_idx;
  tts_pkg::samples_t   in_smp;
  tts_pkg::row_t       old_row;
  tts_pkg::row_t       new_row;
  logic [31:0]         new_cnt;
  tts_pkg::stat_t      cur_stat;
  logic [15:0]         cur_smp;

  assign in_left_idx = PW'(proc_mod(in_left_process));
  assign in_run_idx  = PW'(proc_mod(in_running_process));

  assign in_smp[0] = in_stamp_stop - in_stamp_last_start - in_exception_time;
  assign in_smp[1] = in_stamp_start - in_stamp_stop;
  assign in_smp[2] = in_exception_time;

  assign out_acc  = res_vld_r && out_ready;
  assign res_free = !res_vld_r || (out_ready && beat_r == tts_pkg::CH_EXC);
  assign move     = a_vld_r && res_free;
  assign in_ready = !a_vld_r || move;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 4'd3;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  // A row updated on the same edge that the next switch reads it comes from the result register.
  always_comb begin
    if (fwd_row_r) begin
      old_row = res_row_r;
    end else if (rd_row_set_r) begin
      old_row = rd_row_r;
    end else begin
      old_row = '0;
    end
    if (fwd_cnt_r) begin
      new_cnt = res_cnt_r + 32'd1;
    end else if (rd_cnt_set_r) begin
      new_cnt = rd_cnt_r + 32'd1;
    end else begin
      new_cnt = 32'd1;
    end
  end

  for (genvar c = 0; c < tts_pkg::NUM_CH; c++) begin : g_ch
    assign new_row[c] = tts_pkg::stat_update(old_row[c], a_smp_r[c], shift_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= stat_mem_r[in_left_idx];
      rd_cnt_r <= cnt_mem_r[in_run_idx];
    end
    if (move) begin
      stat_mem_r[a_left_r] <= new_row;
      cnt_mem_r[a_run_r]   <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_set_r <= '0;
      cnt_set_r <= '0;
    end else if (move) begin
      row_set_r[a_left_r] <= 1'b1;
      cnt_set_r[a_run_r]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      fwd_row_r <= 1'b0;
      fwd_cnt_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_vld_r   <= 1'b1;
        fwd_row_r <= move && (a_left_r == in_left_idx);
        fwd_cnt_r <= move && (a_run_r == in_run_idx);
      end else if (move) begin
        a_vld_r   <= 1'b0;
        fwd_row_r <= 1'b0;
        fwd_cnt_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_left_r     <= in_left_idx;
      a_run_r      <= in_run_idx;
      a_smp_r      <= in_smp;
      rd_row_set_r <= row_set_r[in_left_idx];
      rd_cnt_set_r <= cnt_set_r[in_run_idx];
    end
    if (move) begin
      res_row_r <= new_row;
      res_smp_r <= a_smp_r;
      res_cnt_r <= new_cnt;
    end
  end

  always_comb begin
    res_vld_nxt = res_vld_r;
    beat_nxt    = beat_r;
    if (out_acc) begin
      unique case (beat_r)
        tts_pkg::CH_PROC: beat_nxt = tts_pkg::CH_KERN;
        tts_pkg::CH_KERN: beat_nxt = tts_pkg::CH_EXC;
        default: begin
          beat_nxt    = tts_pkg::CH_PROC;
          res_vld_nxt = 1'b0;
        end
      endcase
    end
    if (move) begin
      res_vld_nxt = 1'b1;
      beat_nxt    = tts_pkg::CH_PROC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      beat_r    <= tts_pkg::CH_PROC;
    end else begin
      res_vld_r <= res_vld_nxt;
      beat_r    <= beat_nxt;
    end
  end

  always_comb begin
    unique case (beat_r)
      tts_pkg::CH_PROC: begin
        cur_stat = res_row_r[0];
        cur_smp  = res_smp_r[0];
      end
      tts_pkg::CH_KERN: begin
        cur_stat = res_row_r[1];
        cur_smp  = res_smp_r[1];
      end
      default: begin
        cur_stat = res_row_r[2];
        cur_smp  = res_smp_r[2];
      end
    endcase
  end

  assign out_valid     = res_vld_r;
  assign out_channel   = beat_r;
  assign out_sample    = cur_smp;
  assign out_minimum   = cur_stat.minimum;
  assign out_maximum   = cur_stat.maximum;
  assign out_average   = cur_stat.average;
  assign out_total     = cur_stat.total;
  assign out_run_count = res_cnt_r;
  assign out_last      = (beat_r == tts_pkg::CH_EXC);

  // A switch entering the result register always starts with the process-time beat.
  a_move_starts: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (res_vld_r && beat_r == tts_pkg::CH_PROC))
    else $error("result register did not restart at the process beat");

  // A held switch must block new input until the result register frees up.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !res_free) |-> !in_ready)
    else $error("input accepted while the input register was held");

  // Results stay valid until the exception beat has been taken.
  a_beats_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && beat_r != tts_pkg::CH_EXC) |=> res_vld_r)
    else $error("result beats dropped before the exception beat");

  // Forwarding flags only live alongside a held switch.
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_row_r || fwd_cnt_r) |-> a_vld_r)
    else $error("forwarding flag set without a switch in the input register");

endmodule
